// ===== src/btmx_pkg.sv =====
// Package: request/response types, status and state codes for the max-XOR trie.
`timescale 1ns / 1ps
package btmx_pkg;

	localparam int FIELD_BITS = 62;
	localparam int KEY_BITS_DEF = 62;
	localparam int NODE_COUNT_DEF = 16384;
	localparam int COUNT_BITS = 32;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		ACT_INSERT = 1'b0,
		ACT_QUERY  = 1'b1
	} action_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS,
		S_QROOT,
		S_QRY,
		S_DONE
	} state_t;

	typedef struct packed {
		logic                     action;
		logic [FIELD_BITS-1:0]    key_value;
		logic signed [15:0]       count_change;
	} req_t;

	typedef struct packed {
		logic [FIELD_BITS-1:0]    xor_result;
		logic [1:0]               status;
	} rsp_t;

endpackage

// ===== src/btmx_cell.sv =====
// One key/result bit cell of the shift chain.
`timescale 1ns / 1ps
module btmx_cell (
	input  logic clk,
	input  logic load,
	input  logic shift,
	input  logic load_key,
	input  logic key_in,
	input  logic res_in,
	output logic key_q,
	output logic res_q
);

	always_ff @(posedge clk) begin
		if (load) begin
			key_q <= load_key;
			res_q <= 1'b0;
		end else if (shift) begin
			key_q <= key_in;
			res_q <= res_in;
		end
	end

endmodule

// ===== src/btmx_chain.sv =====
// Row of bit cells: key bits move toward the top, result bits enter at the bottom.
`timescale 1ns / 1ps
module btmx_chain #(
	parameter int KEY_BITS = 62
) (
	input  logic                clk,
	input  logic                load,
	input  logic                shift,
	input  logic [KEY_BITS-1:0] key,
	input  logic                res_bit,
	output logic                key_msb,
	output logic [KEY_BITS-1:0] result
);

	logic [KEY_BITS-1:0] key_c;
	logic [KEY_BITS-1:0] res_c;

	for (genvar i = 0; i < KEY_BITS; i++) begin : g_cell
		logic kin;
		logic rin;
		if (i == 0) begin : g_first
			assign kin = 1'b0;
			assign rin = res_bit;
		end else begin : g_next
			assign kin = key_c[i-1];
			assign rin = res_c[i-1];
		end
		btmx_cell u_cell (
			.clk      (clk),
			.load     (load),
			.shift    (shift),
			.load_key (key[i]),
			.key_in   (kin),
			.res_in   (rin),
			.key_q    (key_c[i]),
			.res_q    (res_c[i])
		);
	end

	assign key_msb = key_c[KEY_BITS-1];
	assign result  = res_c;

endmodule

// ===== src/btmx_store.sv =====
// Node store: one write port, two registered read ports.
`timescale 1ns / 1ps
module btmx_store #(
	parameter int DEPTH = 16384,
	parameter int WIDTH = 60
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic [WIDTH-1:0]         rd_data_a,
	output logic [WIDTH-1:0]         rd_data_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_a <= mem[rd_addr_a];
		rd_data_b <= mem[rd_addr_b];
	end

endmodule

// ===== src/binary_trie_max_xor.sv =====
// Top level: counted binary trie with maximum-XOR query.
//
//  port   dir  meaning
//  start  in   request strobe, taken when busy is low
//  req    in   action, key_value, count_change
//  busy   out  high from request until after done
//  done   out  one-cycle result strobe
//  rsp    out  xor_result, status
//
// Insert and query each make one node store access per trie level, walked in order
// by the bit-cell chain. A full pool ends an insert without walking the trie.
// Reset clears control only; entries above the allocation count read as zero,
// so no clearing pass is needed. The receiver cannot stall: rsp is valid with done.
`timescale 1ns / 1ps
module binary_trie_max_xor #(
	parameter int KEY_BITS   = btmx_pkg::KEY_BITS_DEF,
	parameter int NODE_COUNT = btmx_pkg::NODE_COUNT_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  btmx_pkg::req_t  req,
	output logic            busy,
	output logic            done,
	output btmx_pkg::rsp_t  rsp
);
	import btmx_pkg::*;

	localparam int IW = $clog2(NODE_COUNT);
	localparam int EW = 2 * IW + COUNT_BITS;
	localparam int DW = $clog2(KEY_BITS + 1);

	state_t state_q, state_d;
	logic              act_q;
	logic signed [15:0] delta_q;
	logic [DW-1:0]     depth_q;
	logic [IW-1:0]     node_q;
	logic [IW-1:0]     nf_q;
	logic              root_q;
	logic              stop_q;
	logic              va_q, vb_q;
	logic [IW-1:0]     lnk0_q, lnk1_q;
	status_t           status_q;

	logic              wr_en;
	logic [IW-1:0]     wr_addr, rd_a, rd_b;
	logic [EW-1:0]     wr_data, rdat_a, rdat_b, ent_a, ent_b;

	logic              c_load, c_shift, c_res, key_msb;
	logic [KEY_BITS-1:0] c_res_all;

	logic              accept, pool_full;
	logic [COUNT_BITS-1:0] cnt_new;
	logic signed [COUNT_BITS+1:0] sum;
	logic [IW-1:0]     ins_l0, ins_l1, ins_child;
	logic              ins_alloc, last_ins;
	logic [IW-1:0]     q_opp, q_same, q_next;
	logic [EW-1:0]     e_opp, e_same, e_next;
	logic              q_take_opp, q_take_same;

	btmx_store #(.DEPTH(NODE_COUNT), .WIDTH(EW)) u_store (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_addr_a (rd_a),
		.rd_addr_b (rd_b),
		.rd_data_a (rdat_a),
		.rd_data_b (rdat_b)
	);

	btmx_chain #(.KEY_BITS(KEY_BITS)) u_chain (
		.clk     (clk),
		.load    (c_load),
		.shift   (c_shift),
		.key     (KEY_BITS'(req.key_value)),
		.res_bit (c_res),
		.key_msb (key_msb),
		.result  (c_res_all)
	);

	assign accept    = start && !busy;
	assign pool_full = (32'(nf_q) + 32'(KEY_BITS)) > 32'(NODE_COUNT - 1);
	assign ent_a     = va_q ? rdat_a : '0;
	assign ent_b     = vb_q ? rdat_b : '0;
	assign last_ins  = (depth_q == DW'(KEY_BITS));

	// insert datapath
	always_comb begin
		sum = $signed({2'b00, ent_a[COUNT_BITS-1:0]}) + (COUNT_BITS+2)'(delta_q);
		if (sum < 0) begin
			cnt_new = '0;
		end else if (sum > $signed({2'b00, {COUNT_BITS{1'b1}}})) begin
			cnt_new = '1;
		end else begin
			cnt_new = sum[COUNT_BITS-1:0];
		end
		ins_l0 = ent_a[COUNT_BITS +: IW];
		ins_l1 = ent_a[COUNT_BITS+IW +: IW];
		ins_child = key_msb ? ins_l1 : ins_l0;
		ins_alloc = !last_ins && (ins_child == '0);
		if (ins_alloc) begin
			ins_child = nf_q + 1'b1;
			if (key_msb) begin
				ins_l1 = ins_child;
			end else begin
				ins_l0 = ins_child;
			end
		end
	end

	// query datapath
	always_comb begin
		q_opp  = key_msb ? lnk0_q : lnk1_q;
		q_same = key_msb ? lnk1_q : lnk0_q;
		e_opp  = key_msb ? ent_a : ent_b;
		e_same = key_msb ? ent_b : ent_a;
		q_take_opp  = !stop_q && (q_opp != '0) && (e_opp[COUNT_BITS-1:0] != '0);
		q_take_same = !stop_q && !q_take_opp && (q_same != '0);
		q_next = q_take_opp ? q_opp : q_same;
		e_next = q_take_opp ? e_opp : e_same;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req.action == ACT_QUERY) begin
						state_d = S_QROOT;
					end else if (pool_full) begin
						state_d = S_DONE;
					end else begin
						state_d = S_INS;
					end
				end
			end
			S_INS: begin
				if (last_ins) begin
					state_d = S_DONE;
				end
			end
			S_QROOT: begin
				if (ent_a[COUNT_BITS-1:0] == '0) begin
					state_d = S_DONE;
				end else begin
					state_d = S_QRY;
				end
			end
			S_QRY: begin
				if (depth_q == DW'(KEY_BITS - 1)) begin
					state_d = S_DONE;
				end
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		busy    = (state_q != S_IDLE);
		done    = (state_q == S_DONE);
		c_load  = accept;
		c_shift = 1'b0;
		c_res   = 1'b0;
		wr_en   = 1'b0;
		wr_addr = node_q;
		wr_data = {ins_l1, ins_l0, cnt_new};
		rd_a    = '0;
		rd_b    = '0;
		unique case (state_q)
			S_INS: begin
				wr_en   = 1'b1;
				c_shift = 1'b1;
				rd_a    = ins_child;
			end
			S_QROOT: begin
				rd_a = ent_a[COUNT_BITS +: IW];
				rd_b = ent_a[COUNT_BITS+IW +: IW];
			end
			S_QRY: begin
				c_shift = 1'b1;
				c_res   = q_take_opp;
				rd_a    = e_next[COUNT_BITS +: IW];
				rd_b    = e_next[COUNT_BITS+IW +: IW];
			end
			default: begin
			end
		endcase
		rsp.status = status_q;
		rsp.xor_result = (act_q == ACT_QUERY && status_q == ST_OK) ?
			FIELD_BITS'(c_res_all) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			nf_q     <= '0;
			root_q   <= 1'b0;
			stop_q   <= 1'b0;
			va_q     <= 1'b0;
			vb_q     <= 1'b0;
			status_q <= ST_OK;
			act_q    <= ACT_INSERT;
			depth_q  <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						act_q    <= req.action;
						depth_q  <= '0;
						stop_q   <= 1'b0;
						va_q     <= root_q;
						vb_q     <= 1'b0;
						status_q <= (req.action == ACT_INSERT && pool_full) ?
							ST_FULL : ST_OK;
					end
				end
				S_INS: begin
					root_q  <= 1'b1;
					depth_q <= depth_q + 1'b1;
					va_q    <= !ins_alloc && (ins_child <= nf_q);
					if (ins_alloc) begin
						nf_q <= nf_q + 1'b1;
					end
				end
				S_QROOT: begin
					if (ent_a[COUNT_BITS-1:0] == '0) begin
						status_q <= ST_EMPTY;
					end
					va_q <= (ent_a[COUNT_BITS +: IW] != '0);
					vb_q <= (ent_a[COUNT_BITS+IW +: IW] != '0);
				end
				S_QRY: begin
					depth_q <= depth_q + 1'b1;
					if (!q_take_opp && !q_take_same) begin
						stop_q <= 1'b1;
					end
					va_q <= (e_next[COUNT_BITS +: IW] != '0);
					vb_q <= (e_next[COUNT_BITS+IW +: IW] != '0);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			delta_q <= req.count_change;
			node_q  <= '0;
		end else if (state_q == S_INS) begin
			node_q <= ins_child;
		end
		if (state_q == S_QROOT) begin
			lnk0_q <= ent_a[COUNT_BITS +: IW];
			lnk1_q <= ent_a[COUNT_BITS+IW +: IW];
		end else if (state_q == S_QRY) begin
			lnk0_q <= (q_take_opp || q_take_same) ? e_next[COUNT_BITS +: IW] : '0;
			lnk1_q <= (q_take_opp || q_take_same) ? e_next[COUNT_BITS+IW +: IW] : '0;
		end
	end

endmodule
